[hdl/sfd_pkg.sv]
package sfd_pkg;

  // frame index width, enough for the longest frame of seven bytes
  localparam int unsigned IDX_W = 3;

  // bytes of a frame that are kept and reported
  localparam int unsigned HELD_BYTES = 4;

  // sync marker bit of the first byte
  localparam int unsigned SYNC_BIT = 7;

  // register reset values
  localparam logic [10:0] ID_BASE_RST = 11'h580;
  localparam logic [3:0]  MAX_ID_RST  = 4'd4;

  // register indexes on the configuration port
  localparam logic REG_ID_BASE = 1'b0;
  localparam logic REG_MAX_ID  = 1'b1;

  // one completed frame as handed from the framer to the result stage
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
  } frame_rec_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[hdl/sfd_front.sv]
module sfd_front #(
  parameter int unsigned FRAME_BYTES = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  sfd_pkg::q_stat_t    q_stat,
  output logic                q_push,
  output sfd_pkg::frame_rec_t q_wdata
);
  import sfd_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       held_r   [HELD_BYTES];
  logic [7:0]       held_nxt [HELD_BYTES];
  logic             accept;
  logic [IDX_W-1:0] idx_inc;

  // hold off the link only while no frame slot is free
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign idx_inc  = idx_r + IDX_W'(1);

  // classify the word: drop, start, store, or close the frame
  always_comb begin
    idx_nxt = idx_r;
    q_push  = 1'b0;
    for (int i = 0; i < HELD_BYTES; i++) begin
      held_nxt[i] = held_r[i];
    end
    if (accept) begin
      if (idx_r == '0) begin
        if (in_rx_byte[SYNC_BIT]) begin
          held_nxt[0] = in_rx_byte;
          idx_nxt     = IDX_W'(1);
        end
      end else begin
        if (idx_r < IDX_W'(HELD_BYTES)) begin
          held_nxt[idx_r[1:0]] = in_rx_byte;
        end
        if (idx_inc >= LAST_IDX) begin
          idx_nxt = '0;
          q_push  = 1'b1;
        end else begin
          idx_nxt = idx_inc;
        end
      end
    end
  end

  // record includes the word taken in this cycle
  assign q_wdata = '{byte0: held_nxt[0], byte1: held_nxt[1],
                     byte2: held_nxt[2], byte3: held_nxt[3]};

  // frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // kept frame bytes
  always_ff @(posedge clk) begin
    for (int i = 0; i < HELD_BYTES; i++) begin
      held_r[i] <= held_nxt[i];
    end
  end

endmodule

[hdl/sfd_queue.sv]
module sfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sfd_pkg::frame_rec_t wdata,
  input  logic                pop,
  output sfd_pkg::frame_rec_t rdata,
  output sfd_pkg::q_stat_t    stat
);
  import sfd_pkg::*;

  frame_rec_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rdata      = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // frame storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hdl/sfd_back.sv]
module sfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [10:0]         id_base,
  input  logic [3:0]          max_servo_id,
  input  sfd_pkg::q_stat_t    q_stat,
  input  sfd_pkg::frame_rec_t q_rdata,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [10:0]         out_can_std_id,
  output logic [13:0]         out_position,
  output logic [7:0]          out_frame_byte0,
  output logic [7:0]          out_frame_byte1,
  output logic [7:0]          out_frame_byte2,
  output logic [7:0]          out_frame_byte3,
  output logic [15:0]         out_frame_count
);
  import sfd_pkg::*;

  logic        valid_r, valid_nxt;
  logic [15:0] count_r, count_nxt;
  logic [3:0]  servo;
  logic [3:0]  servo_raw;
  logic [10:0] can_id_r;
  logic [13:0] pos_r;
  frame_rec_t  rec_r;

  // take a frame when the output word is free or leaving
  assign q_pop     = !q_stat.empty && (!valid_r || !out_stall);
  assign valid_nxt = q_pop || (valid_r && out_stall);
  assign count_nxt = count_r + 16'd1;

  // servo id check, out of range maps to servo one
  assign servo_raw = q_rdata.byte1[7:4];
  always_comb begin
    servo = servo_raw;
    if (servo_raw == 4'd0 || servo_raw > max_servo_id) begin
      servo = 4'd1;
    end
  end

  // control and frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= 16'd0;
    end else begin
      valid_r <= valid_nxt;
      if (q_pop) begin
        count_r <= count_nxt;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      can_id_r <= id_base + {7'd0, servo};
      pos_r    <= {q_rdata.byte2[6:0], q_rdata.byte3[6:0]};
      rec_r    <= q_rdata;
    end
  end

  assign out_valid       = valid_r;
  assign out_can_std_id  = can_id_r;
  assign out_position    = pos_r;
  assign out_frame_byte0 = rec_r.byte0;
  assign out_frame_byte1 = rec_r.byte1;
  assign out_frame_byte2 = rec_r.byte2;
  assign out_frame_byte3 = rec_r.byte3;
  assign out_frame_count = count_r;

endmodule

[hdl/servo_feedback_deframer_top.sv]
// Servo feedback deframer: takes one serial byte per cycle when not stalled.
// While idle, a byte with bit 7 set opens a frame and other bytes are dropped;
// once open, every byte counts, and the FRAME_BYTES-th byte closes the frame.
// The framer hands each finished frame to a two-entry queue, and the result
// stage turns it into one word: CAN id (id_base plus servo id, with an id
// of zero or above max_servo_id replaced by one), 14-bit position from the
// low seven bits of bytes 2 and 3, bytes 0 to 3 as received, and a frame
// count that wraps at 16 bits. A closed frame goes into the queue and, once
// the result stage is free, into the registered output word under out_valid.
// in_stall rises only when the queue holds two finished frames, i.e. while
// out_stall has held back delivery for long enough to fill it. Registers:
// id_base at address 0 (reset 0x580), max_servo_id at address 4 (reset 4);
// write them only while no frame is in flight.
module servo_feedback_deframer_top #(
  parameter int unsigned FRAME_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_can_std_id,
  output logic [13:0] out_position,
  output logic [7:0]  out_frame_byte0,
  output logic [7:0]  out_frame_byte1,
  output logic [7:0]  out_frame_byte2,
  output logic [7:0]  out_frame_byte3,
  output logic [15:0] out_frame_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfd_pkg::*;

  logic        cfg_wr;
  logic        cfg_sel;
  logic [10:0] id_base_r;
  logic [3:0]  max_id_r;
  logic        q_push;
  logic        q_pop;
  frame_rec_t  q_wdata;
  frame_rec_t  q_rdata;
  q_stat_t     q_stat;

  // register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_base_r <= ID_BASE_RST;
      max_id_r  <= MAX_ID_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_ID_BASE: id_base_r <= pwdata[10:0];
        REG_MAX_ID:  max_id_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_ID_BASE: prdata = {21'd0, id_base_r};
      REG_MAX_ID:  prdata = {28'd0, max_id_r};
      default:     prdata = 32'd0;
    endcase
  end

  // framer
  sfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // finished frame queue
  sfd_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .stat (q_stat)
  );

  // result stage
  sfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .id_base        (id_base_r),
    .max_servo_id   (max_id_r),
    .q_stat         (q_stat),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_can_std_id (out_can_std_id),
    .out_position   (out_position),
    .out_frame_byte0(out_frame_byte0),
    .out_frame_byte1(out_frame_byte1),
    .out_frame_byte2(out_frame_byte2),
    .out_frame_byte3(out_frame_byte3),
    .out_frame_count(out_frame_count)
  );

endmodule
